>>> rtl/core/vls_pkg.sv
package vls_pkg;

  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 10;
  localparam int MODE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUTY_W-1:0] FULL_LEVEL = 10'd1000;

  // light mode codes; anything else acts as off
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DRL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOW   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIGH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

  // lamp target commands
  localparam logic [CMD_W-1:0] CMD_KEEP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ON   = 2'd2;

  // sequence triggers
  localparam logic [CMD_W-1:0] TRIG_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] TRIG_WELCOME = 2'd1;
  localparam logic [CMD_W-1:0] TRIG_GOODBYE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ON      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OFF     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WELCOME      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOODBYE      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOODBYE_HOLD = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INC     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INC     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRL_LEVEL    = 8'd7;

  typedef struct packed {
    logic [PERIOD_W-1:0] turn_on_ms;
    logic [PERIOD_W-1:0] turn_off_ms;
    logic [PERIOD_W-1:0] welcome_ms;
    logic [PERIOD_W-1:0] goodbye_ms;
    logic [PERIOD_W-1:0] goodbye_hold_ms;
    logic [DUTY_W-1:0]   ramp_inc;
    logic [DUTY_W-1:0]   fade_inc;
    logic [DUTY_W-1:0]   drl_level;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [MODE_W-1:0] light_mode;
    logic              turn_left_request;
    logic              turn_right_request;
    logic              hazard_request;
    logic              brake_on;
    logic              reverse_selected;
    logic [CMD_W-1:0]  interior_command;
    logic [CMD_W-1:0]  courtesy_command;
    logic [CMD_W-1:0]  sequence_trigger;
  } tick_t;

  typedef struct packed {
    logic              turn_left_lamp;
    logic              turn_right_lamp;
    logic [DUTY_W-1:0] low_beam_duty;
    logic [DUTY_W-1:0] high_beam_duty;
    logic [DUTY_W-1:0] drl_duty;
    logic              brake_lamp;
    logic              reverse_lamp;
    logic [DUTY_W-1:0] interior_duty;
    logic [DUTY_W-1:0] courtesy_duty;
  } lamp_t;

endpackage

>>> rtl/core/vls_if.sv
interface vls_tick_if;
  import vls_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [MODE_W-1:0] light_mode;
  logic              turn_left_request;
  logic              turn_right_request;
  logic              hazard_request;
  logic              brake_on;
  logic              reverse_selected;
  logic [CMD_W-1:0]  interior_command;
  logic [CMD_W-1:0]  courtesy_command;
  logic [CMD_W-1:0]  sequence_trigger;

  modport source (
    output valid, now_ms, light_mode, turn_left_request, turn_right_request,
           hazard_request, brake_on, reverse_selected, interior_command,
           courtesy_command, sequence_trigger,
    input  ready
  );

  modport sink (
    input  valid, now_ms, light_mode, turn_left_request, turn_right_request,
           hazard_request, brake_on, reverse_selected, interior_command,
           courtesy_command, sequence_trigger,
    output ready
  );
endinterface

interface vls_lamp_if;
  import vls_pkg::*;

  logic              valid;
  logic              ready;
  logic              turn_left_lamp;
  logic              turn_right_lamp;
  logic [DUTY_W-1:0] low_beam_duty;
  logic [DUTY_W-1:0] high_beam_duty;
  logic [DUTY_W-1:0] drl_duty;
  logic              brake_lamp;
  logic              reverse_lamp;
  logic [DUTY_W-1:0] interior_duty;
  logic [DUTY_W-1:0] courtesy_duty;

  modport source (
    output valid, turn_left_lamp, turn_right_lamp, low_beam_duty, high_beam_duty,
           drl_duty, brake_lamp, reverse_lamp, interior_duty, courtesy_duty,
    input  ready
  );

  modport sink (
    input  valid, turn_left_lamp, turn_right_lamp, low_beam_duty, high_beam_duty,
           drl_duty, brake_lamp, reverse_lamp, interior_duty, courtesy_duty,
    output ready
  );
endinterface

interface vls_cfg_if;
  import vls_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/vls_cfg.sv
module vls_cfg (
  input  logic         clk,
  input  logic         rst,
  vls_cfg_if.sink      cfg,
  output vls_pkg::cfg_t regs
);
  import vls_pkg::*;

  cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_TURN_ON:      regs_next.turn_on_ms      = cfg.data;
        REG_TURN_OFF:     regs_next.turn_off_ms     = cfg.data;
        REG_WELCOME:      regs_next.welcome_ms      = cfg.data;
        REG_GOODBYE:      regs_next.goodbye_ms      = cfg.data;
        REG_GOODBYE_HOLD: regs_next.goodbye_hold_ms = cfg.data;
        REG_RAMP_INC:     regs_next.ramp_inc        = cfg.data[DUTY_W-1:0];
        REG_FADE_INC:     regs_next.fade_inc        = cfg.data[DUTY_W-1:0];
        REG_DRL_LEVEL:    regs_next.drl_level       = cfg.data[DUTY_W-1:0];
        default:          regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.turn_on_ms      <= 16'd500;
      regs.turn_off_ms     <= 16'd500;
      regs.welcome_ms      <= 16'd10000;
      regs.goodbye_ms      <= 16'd30000;
      regs.goodbye_hold_ms <= 16'd5000;
      regs.ramp_inc        <= 10'd50;
      regs.fade_inc        <= 10'd40;
      regs.drl_level       <= 10'd400;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

>>> rtl/core/vls_step.sv
module vls_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  vls_pkg::cfg_t  regs,
  input  vls_pkg::tick_t tick_q,
  output vls_pkg::lamp_t lamp_next
);
  import vls_pkg::*;

  logic              flash_phase, flash_phase_next;
  logic [TIME_W-1:0] last_toggle_time, last_toggle_time_next;
  logic [DUTY_W-1:0] headlight_level, headlight_level_next;
  logic [DUTY_W-1:0] interior_level, interior_level_next;
  logic              interior_target_on, interior_target_on_next;
  logic [DUTY_W-1:0] courtesy_level, courtesy_level_next;
  logic              courtesy_target_on, courtesy_target_on_next;
  logic              welcome_running, welcome_running_next;
  logic              goodbye_running, goodbye_running_next;
  logic [TIME_W-1:0] sequence_start_time, sequence_start_time_next;

  logic              any_req;
  logic              toggle;
  logic [TIME_W-1:0] since_toggle;
  logic [TIME_W-1:0] elapsed;
  logic [PERIOD_W-1:0] period;
  logic [DUTY_W:0]   head_sum;
  logic              want_head;
  logic              want_high;
  logic              int_tgt;
  logic              cour_tgt;

  function automatic logic [DUTY_W-1:0] fade_toward(
    input logic [DUTY_W-1:0] level,
    input logic              target_on,
    input logic [DUTY_W-1:0] step
  );
    logic [DUTY_W:0] sum;
    logic [DUTY_W-1:0] res;
    sum = {1'b0, level} + {1'b0, step};
    res = level;
    if (target_on && (level < FULL_LEVEL)) begin
      res = (sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : sum[DUTY_W-1:0];
    end else if (!target_on && (level != '0)) begin
      res = (level >= step) ? level - step : '0;
    end
    return res;
  endfunction

  always_comb begin
    // commands land first
    int_tgt = interior_target_on;
    if (tick_q.interior_command == CMD_OFF) int_tgt = 1'b0;
    else if (tick_q.interior_command == CMD_ON) int_tgt = 1'b1;
    cour_tgt = courtesy_target_on;
    if (tick_q.courtesy_command == CMD_OFF) cour_tgt = 1'b0;
    else if (tick_q.courtesy_command == CMD_ON) cour_tgt = 1'b1;

    welcome_running_next     = welcome_running;
    goodbye_running_next     = goodbye_running;
    sequence_start_time_next = sequence_start_time;
    if (tick_q.sequence_trigger == TRIG_WELCOME) begin
      welcome_running_next     = 1'b1;
      goodbye_running_next     = 1'b0;
      sequence_start_time_next = tick_q.now_ms;
    end else if (tick_q.sequence_trigger == TRIG_GOODBYE) begin
      goodbye_running_next     = 1'b1;
      welcome_running_next     = 1'b0;
      sequence_start_time_next = tick_q.now_ms;
    end

    // flasher, wrapping time difference
    any_req      = tick_q.turn_left_request | tick_q.turn_right_request |
                   tick_q.hazard_request;
    period       = flash_phase ? regs.turn_on_ms : regs.turn_off_ms;
    since_toggle = tick_q.now_ms - last_toggle_time;
    toggle       = any_req && (since_toggle >= {{(TIME_W-PERIOD_W){1'b0}}, period});
    flash_phase_next      = any_req ? (flash_phase ^ toggle) : 1'b0;
    last_toggle_time_next = toggle ? tick_q.now_ms : last_toggle_time;

    // headlight soft start
    want_head = (tick_q.light_mode == MODE_LOW) || (tick_q.light_mode == MODE_HIGH);
    want_high = (tick_q.light_mode == MODE_HIGH) || (tick_q.light_mode == MODE_FLASH);
    head_sum  = {1'b0, headlight_level} + {1'b0, regs.ramp_inc};
    if (!want_head) begin
      headlight_level_next = '0;
    end else if (headlight_level < FULL_LEVEL) begin
      headlight_level_next = (head_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                             : head_sum[DUTY_W-1:0];
    end else begin
      headlight_level_next = headlight_level;
    end

    interior_level_next = fade_toward(interior_level, int_tgt, regs.fade_inc);
    courtesy_level_next = fade_toward(courtesy_level, cour_tgt, regs.fade_inc);

    lamp_next.turn_left_lamp  = flash_phase_next &
                                (tick_q.turn_left_request | tick_q.hazard_request);
    lamp_next.turn_right_lamp = flash_phase_next &
                                (tick_q.turn_right_request | tick_q.hazard_request);
    lamp_next.low_beam_duty   = want_head ? headlight_level_next : '0;
    lamp_next.high_beam_duty  = want_high ? headlight_level_next : '0;
    lamp_next.drl_duty        = (tick_q.light_mode == MODE_DRL) ? regs.drl_level : '0;
    lamp_next.brake_lamp      = tick_q.brake_on;
    lamp_next.reverse_lamp    = tick_q.reverse_selected;
    lamp_next.interior_duty   = interior_level_next;
    lamp_next.courtesy_duty   = courtesy_level_next;

    // sequences set targets for the next tick; welcome drives the DRL now
    elapsed                 = tick_q.now_ms - sequence_start_time_next;
    interior_target_on_next = int_tgt;
    courtesy_target_on_next = cour_tgt;
    if (welcome_running_next) begin
      if (elapsed < {{(TIME_W-PERIOD_W){1'b0}}, regs.welcome_ms}) begin
        interior_target_on_next = 1'b1;
        courtesy_target_on_next = 1'b1;
        lamp_next.drl_duty      = regs.drl_level;
      end else begin
        welcome_running_next = 1'b0;
      end
    end
    if (goodbye_running_next) begin
      if (elapsed < {{(TIME_W-PERIOD_W){1'b0}}, regs.goodbye_ms}) begin
        courtesy_target_on_next =
          !(elapsed > {{(TIME_W-PERIOD_W){1'b0}}, regs.goodbye_hold_ms});
      end else begin
        goodbye_running_next    = 1'b0;
        courtesy_target_on_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_phase         <= 1'b0;
      last_toggle_time    <= '0;
      headlight_level     <= '0;
      interior_level      <= '0;
      interior_target_on  <= 1'b0;
      courtesy_level      <= '0;
      courtesy_target_on  <= 1'b0;
      welcome_running     <= 1'b0;
      goodbye_running     <= 1'b0;
      sequence_start_time <= '0;
    end else if (advance) begin
      flash_phase         <= flash_phase_next;
      last_toggle_time    <= last_toggle_time_next;
      headlight_level     <= headlight_level_next;
      interior_level      <= interior_level_next;
      interior_target_on  <= interior_target_on_next;
      courtesy_level      <= courtesy_level_next;
      courtesy_target_on  <= courtesy_target_on_next;
      welcome_running     <= welcome_running_next;
      goodbye_running     <= goodbye_running_next;
      sequence_start_time <= sequence_start_time_next;
    end
  end

endmodule

>>> rtl/core/vehicle_light_sequencer.sv
// Channel  Modport  Word
// -------  -------  ---------------------------------------------------
// tick     sink     one update tick: timestamp, mode, requests, commands
// lamps    source   one set of lamp drives and duties per tick
// cfg      sink     register index and write data, always ready
//
// One tick a cycle sustained while the lamps side is ready; a tick passes through
// the input register and then the result register around the step logic.
// Synchronous reset restores the register defaults, clears the step state and the valid flags.
// A stalled result holds the step; the input register still takes a word
// whenever the step can move or is empty.
module vehicle_light_sequencer (
  input  logic      clk,
  input  logic      rst,
  vls_tick_if.sink  tick,
  vls_lamp_if.source lamps,
  vls_cfg_if.sink   cfg
);
  import vls_pkg::*;

  cfg_t  regs;
  tick_t tick_q;
  logic  tick_valid_q;
  lamp_t lamp_next;
  lamp_t lamp_q;
  logic  lamp_valid_q;
  logic  advance;

  assign advance    = tick_valid_q && (!lamp_valid_q || lamps.ready);
  assign tick.ready = !tick_valid_q || advance;

  vls_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  vls_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .regs      (regs),
    .tick_q    (tick_q),
    .lamp_next (lamp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid_q <= 1'b0;
      lamp_valid_q <= 1'b0;
    end else begin
      if (tick.ready) tick_valid_q <= tick.valid;
      if (advance) lamp_valid_q <= 1'b1;
      else if (lamps.ready) lamp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      tick_q.now_ms             <= tick.now_ms;
      tick_q.light_mode         <= tick.light_mode;
      tick_q.turn_left_request  <= tick.turn_left_request;
      tick_q.turn_right_request <= tick.turn_right_request;
      tick_q.hazard_request     <= tick.hazard_request;
      tick_q.brake_on           <= tick.brake_on;
      tick_q.reverse_selected   <= tick.reverse_selected;
      tick_q.interior_command   <= tick.interior_command;
      tick_q.courtesy_command   <= tick.courtesy_command;
      tick_q.sequence_trigger   <= tick.sequence_trigger;
    end
    if (advance) lamp_q <= lamp_next;
  end

  assign lamps.valid           = lamp_valid_q;
  assign lamps.turn_left_lamp  = lamp_q.turn_left_lamp;
  assign lamps.turn_right_lamp = lamp_q.turn_right_lamp;
  assign lamps.low_beam_duty   = lamp_q.low_beam_duty;
  assign lamps.high_beam_duty  = lamp_q.high_beam_duty;
  assign lamps.drl_duty        = lamp_q.drl_duty;
  assign lamps.brake_lamp      = lamp_q.brake_lamp;
  assign lamps.reverse_lamp    = lamp_q.reverse_lamp;
  assign lamps.interior_duty   = lamp_q.interior_duty;
  assign lamps.courtesy_duty   = lamp_q.courtesy_duty;

endmodule

>>> bench/vehicle_light_sequencer_test.sv
`timescale 1ns / 1ps

module vehicle_light_sequencer_test;
  import vls_pkg::*;

  // codes the package leaves unnamed
  localparam logic [MODE_W-1:0]    MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_SPARE_C = 3'd7;
  localparam logic [CMD_W-1:0]     CMD_SPARE    = 2'd3;
  localparam logic [CMD_W-1:0]     TRIG_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE     = 8'hA5;

  // turn request masks: {hazard, right, left}
  localparam logic [2:0] TURN_NONE = 3'b000;
  localparam logic [2:0] TURN_L    = 3'b001;
  localparam logic [2:0] TURN_R    = 3'b010;
  localparam logic [2:0] TURN_HAZ  = 3'b100;

  logic clk;
  logic rst;

  vls_tick_if tick_bus ();
  vls_lamp_if lamp_bus ();
  vls_cfg_if  cfg_bus ();

  vehicle_light_sequencer u_dut (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_bus),
    .lamps (lamp_bus),
    .cfg   (cfg_bus)
  );

  // predictor registers and lamp state
  logic [15:0] on_ms_r      = 16'd500;
  logic [15:0] off_ms_r     = 16'd500;
  logic [15:0] welcome_ms_r = 16'd10000;
  logic [15:0] goodbye_ms_r = 16'd30000;
  logic [15:0] hold_ms_r    = 16'd5000;
  logic [9:0]  ramp_r       = 10'd50;
  logic [9:0]  fade_r       = 10'd40;
  logic [9:0]  drl_r        = 10'd400;

  bit          flash_on    = 1'b0;
  logic [31:0] last_toggle = '0;
  int unsigned head_lvl    = 0;
  int unsigned int_lvl     = 0;
  int unsigned crt_lvl     = 0;
  bit          int_tgt     = 1'b0;
  bit          crt_tgt     = 1'b0;
  bit          welcome_on  = 1'b0;
  bit          goodbye_on  = 1'b0;
  logic [31:0] seq_start   = '0;

  lamp_t       lamps_due[$];
  int          fails        = 0;
  int          results_seen = 0;
  int          writes_done  = 0;

  // stimulus shaping
  logic [31:0] clock_ms  = '0;
  logic [2:0]  cur_mode  = MODE_OFF;
  logic [2:0]  cur_turn  = TURN_NONE;
  int          send_idle = 0;
  int          rx_stall  = 0;
  int          noise_pct = 0;
  int          hold_req  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("vehicle_light_sequencer test failed");
    $finish;
  end

  function automatic int unsigned fade_level(int unsigned lvl, bit goal_on);
    int unsigned goal;
    goal = goal_on ? FULL_LEVEL : 0;
    if (lvl < goal) begin
      lvl += fade_r;
      if (lvl > goal) lvl = goal;
    end else if (lvl > goal) begin
      lvl = (lvl >= fade_r) ? lvl - fade_r : 0;
    end
    return lvl;
  endfunction

  function automatic lamp_t advance_lamps(tick_t t);
    lamp_t       r;
    logic [31:0] elapsed;
    logic [15:0] period;
    logic [9:0]  drl;
    bit          want_head;
    bit          want_high;
    bit          any_turn;

    // commands first
    if (t.interior_command == CMD_OFF) int_tgt = 1'b0;
    else if (t.interior_command == CMD_ON) int_tgt = 1'b1;
    if (t.courtesy_command == CMD_OFF) crt_tgt = 1'b0;
    else if (t.courtesy_command == CMD_ON) crt_tgt = 1'b1;
    if (t.sequence_trigger == TRIG_WELCOME) begin
      welcome_on = 1'b1;
      goodbye_on = 1'b0;
      seq_start  = t.now_ms;
    end else if (t.sequence_trigger == TRIG_GOODBYE) begin
      goodbye_on = 1'b1;
      welcome_on = 1'b0;
      seq_start  = t.now_ms;
    end

    any_turn = t.turn_left_request | t.turn_right_request | t.hazard_request;
    if (any_turn) begin
      period  = flash_on ? on_ms_r : off_ms_r;
      elapsed = t.now_ms - last_toggle;
      if (elapsed >= period) begin
        flash_on    = !flash_on;
        last_toggle = t.now_ms;
      end
    end else begin
      flash_on = 1'b0;
    end
    r.turn_left_lamp  = flash_on & (t.turn_left_request | t.hazard_request);
    r.turn_right_lamp = flash_on & (t.turn_right_request | t.hazard_request);

    want_head = (t.light_mode == MODE_LOW) || (t.light_mode == MODE_HIGH);
    want_high = (t.light_mode == MODE_HIGH) || (t.light_mode == MODE_FLASH);
    if (want_head) begin
      if (head_lvl < FULL_LEVEL) begin
        head_lvl += ramp_r;
        if (head_lvl > FULL_LEVEL) head_lvl = FULL_LEVEL;
      end
    end else begin
      head_lvl = 0;
    end
    r.low_beam_duty  = want_head ? DUTY_W'(head_lvl) : '0;
    r.high_beam_duty = want_high ? DUTY_W'(head_lvl) : '0;
    drl = (t.light_mode == MODE_DRL) ? drl_r : '0;

    int_lvl = fade_level(int_lvl, int_tgt);
    crt_lvl = fade_level(crt_lvl, crt_tgt);

    // sequence targets land on the next tick, the DRL override on this one
    if (welcome_on) begin
      elapsed = t.now_ms - seq_start;
      if (elapsed < welcome_ms_r) begin
        int_tgt = 1'b1;
        crt_tgt = 1'b1;
        drl     = drl_r;
      end else begin
        welcome_on = 1'b0;
      end
    end
    if (goodbye_on) begin
      elapsed = t.now_ms - seq_start;
      if (elapsed < goodbye_ms_r) begin
        crt_tgt = (elapsed > hold_ms_r) ? 1'b0 : 1'b1;
      end else begin
        goodbye_on = 1'b0;
        crt_tgt    = 1'b0;
      end
    end

    r.drl_duty      = drl;
    r.brake_lamp    = t.brake_on;
    r.reverse_lamp  = t.reverse_selected;
    r.interior_duty = DUTY_W'(int_lvl);
    r.courtesy_duty = DUTY_W'(crt_lvl);
    return r;
  endfunction

  function automatic tick_t tick_of(logic [31:0] now, logic [2:0] mode, logic [2:0] turn,
                                    bit brake, bit rev, logic [1:0] icmd, logic [1:0] ccmd,
                                    logic [1:0] trig);
    tick_t t;
    t.now_ms             = now;
    t.light_mode         = mode;
    t.turn_left_request  = turn[0];
    t.turn_right_request = turn[1];
    t.hazard_request     = turn[2];
    t.brake_on           = brake;
    t.reverse_selected   = rev;
    t.interior_command   = icmd;
    t.courtesy_command   = ccmd;
    t.sequence_trigger   = trig;
    return t;
  endfunction

  // mostly a steady drive with slowly changing mode and turn switches; now and then a wild timestamp
  function automatic tick_t next_tick(int unsigned step_lo, int unsigned step_hi);
    logic [1:0] icmd;
    logic [1:0] ccmd;
    logic [1:0] trig;
    int unsigned pick;
    if ($urandom_range(99) < noise_pct) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(step_lo, step_hi);
    if ($urandom_range(99) < 12) cur_mode = 3'($urandom_range(0, 7));
    if ($urandom_range(99) < 10) cur_turn = 3'($urandom_range(0, 7));
    icmd = ($urandom_range(99) < 80) ? CMD_KEEP : 2'($urandom_range(1, 3));
    ccmd = ($urandom_range(99) < 80) ? CMD_KEEP : 2'($urandom_range(1, 3));
    pick = $urandom_range(99);
    if (pick < 4) trig = TRIG_WELCOME;
    else if (pick < 8) trig = TRIG_GOODBYE;
    else if (pick < 10) trig = TRIG_SPARE;
    else trig = TRIG_NONE;
    return tick_of(clock_ms, cur_mode, cur_turn, 1'($urandom_range(1)),
                   1'($urandom_range(1)), icmd, ccmd, trig);
  endfunction

  task automatic put_tick(input tick_t t);
    @(negedge clk);
    tick_bus.valid              <= 1'b1;
    tick_bus.now_ms             <= t.now_ms;
    tick_bus.light_mode         <= t.light_mode;
    tick_bus.turn_left_request  <= t.turn_left_request;
    tick_bus.turn_right_request <= t.turn_right_request;
    tick_bus.hazard_request     <= t.hazard_request;
    tick_bus.brake_on           <= t.brake_on;
    tick_bus.reverse_selected   <= t.reverse_selected;
    tick_bus.interior_command   <= t.interior_command;
    tick_bus.courtesy_command   <= t.courtesy_command;
    tick_bus.sequence_trigger   <= t.sequence_trigger;
    do @(posedge clk); while (!tick_bus.ready);
    lamps_due.push_back(advance_lamps(t));
  endtask

  task automatic park_sender();
    @(negedge clk);
    tick_bus.valid <= 1'b0;
  endtask

  task automatic run_ticks(int n, int unsigned step_lo, int unsigned step_hi);
    repeat (n) begin
      while ($urandom_range(99) < send_idle) park_sender();
      put_tick(next_tick(step_lo, step_hi));
    end
    park_sender();
  endtask

  task automatic wait_results();
    while (lamps_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_TURN_ON:      on_ms_r      = data;
      REG_TURN_OFF:     off_ms_r     = data;
      REG_WELCOME:      welcome_ms_r = data;
      REG_GOODBYE:      goodbye_ms_r = data;
      REG_GOODBYE_HOLD: hold_ms_r    = data;
      REG_RAMP_INC:     ramp_r       = data[DUTY_W-1:0];
      REG_FADE_INC:     fade_r       = data[DUTY_W-1:0];
      REG_DRL_LEVEL:    drl_r        = data[DUTY_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] on_ms, logic [15:0] off_ms, logic [15:0] wel_ms,
                           logic [15:0] bye_ms, logic [15:0] hold_ms, logic [15:0] ramp,
                           logic [15:0] fade, logic [15:0] drl);
    park_sender();
    wait_results();
    write_reg(REG_TURN_ON, on_ms);
    write_reg(REG_TURN_OFF, off_ms);
    write_reg(REG_WELCOME, wel_ms);
    write_reg(REG_GOODBYE, bye_ms);
    write_reg(REG_GOODBYE_HOLD, hold_ms);
    write_reg(REG_RAMP_INC, ramp);
    write_reg(REG_FADE_INC, fade);
    write_reg(REG_DRL_LEVEL, drl);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    int hold_left;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      lamp_bus.ready <= 1'b0;
    end else begin
      lamp_bus.ready <= ($urandom_range(99) >= rx_stall);
    end
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    lamp_t want;
    if (!rst && lamp_bus.valid && lamp_bus.ready) begin
      if (lamps_due.size() == 0) begin
        $error("lamp word with no tick outstanding");
        fails++;
      end else begin
        want = lamps_due.pop_front();
        compare_field("turn_left_lamp", 32'(want.turn_left_lamp),
                      32'(lamp_bus.turn_left_lamp));
        compare_field("turn_right_lamp", 32'(want.turn_right_lamp),
                      32'(lamp_bus.turn_right_lamp));
        compare_field("low_beam_duty", 32'(want.low_beam_duty),
                      32'(lamp_bus.low_beam_duty));
        compare_field("high_beam_duty", 32'(want.high_beam_duty),
                      32'(lamp_bus.high_beam_duty));
        compare_field("drl_duty", 32'(want.drl_duty), 32'(lamp_bus.drl_duty));
        compare_field("brake_lamp", 32'(want.brake_lamp), 32'(lamp_bus.brake_lamp));
        compare_field("reverse_lamp", 32'(want.reverse_lamp), 32'(lamp_bus.reverse_lamp));
        compare_field("interior_duty", 32'(want.interior_duty),
                      32'(lamp_bus.interior_duty));
        compare_field("courtesy_duty", 32'(want.courtesy_duty),
                      32'(lamp_bus.courtesy_duty));
        results_seen++;
      end
    end
  end

  // every mode, command and trigger code, flasher edges and the timestamp wrap
  task automatic test_directed_ticks();
    int k;
    send_idle = 0;
    rx_stall  = 0;
    put_tick(tick_of(32'd0, MODE_OFF, TURN_NONE, 1'b0, 1'b0, CMD_KEEP, CMD_KEEP,
                     TRIG_NONE));
    put_tick(tick_of(32'd100, MODE_DRL, TURN_L, 1'b1, 1'b0, CMD_ON, CMD_KEEP, TRIG_NONE));
    put_tick(tick_of(32'd200, MODE_LOW, TURN_R, 1'b0, 1'b1, CMD_KEEP, CMD_ON, TRIG_NONE));
    put_tick(tick_of(32'd300, MODE_HIGH, TURN_HAZ, 1'b1, 1'b1, CMD_SPARE, CMD_SPARE,
                     TRIG_NONE));
    put_tick(tick_of(32'd400, MODE_FLASH, TURN_HAZ, 1'b0, 1'b0, CMD_KEEP, CMD_KEEP,
                     TRIG_SPARE));
    put_tick(tick_of(32'd500, MODE_SPARE_A, TURN_L, 1'b0, 1'b0, CMD_KEEP, CMD_KEEP,
                     TRIG_WELCOME));
    put_tick(tick_of(32'd600, MODE_SPARE_B, TURN_R, 1'b0, 1'b0, CMD_OFF, CMD_OFF,
                     TRIG_NONE));
    put_tick(tick_of(32'd700, MODE_SPARE_C, TURN_L | TURN_R | TURN_HAZ, 1'b1, 1'b0,
                     CMD_KEEP, CMD_KEEP, TRIG_GOODBYE));
    for (k = 8; k < 16; k++)
      put_tick(tick_of(32'(k * 100), (k < 12) ? MODE_LOW : MODE_HIGH, TURN_L | TURN_R,
                       1'b0, 1'b0, (k == 10) ? CMD_ON : CMD_KEEP, CMD_KEEP,
                       (k == 13) ? TRIG_WELCOME : TRIG_NONE));
    put_tick(tick_of(32'hFFFF_FF9C, MODE_HIGH, TURN_HAZ, 1'b0, 1'b1, CMD_KEEP, CMD_KEEP,
                     TRIG_GOODBYE));
    put_tick(tick_of(32'hFFFF_FFFF, MODE_HIGH, TURN_HAZ, 1'b1, 1'b1, CMD_KEEP, CMD_ON,
                     TRIG_NONE));
    put_tick(tick_of(32'h0000_0063, MODE_LOW, TURN_HAZ, 1'b1, 1'b0, CMD_OFF, CMD_KEEP,
                     TRIG_NONE));
    put_tick(tick_of(32'h8000_0000, MODE_OFF, TURN_NONE, 1'b0, 1'b0, CMD_KEEP, CMD_KEEP,
                     TRIG_NONE));
    clock_ms = 32'h8000_0000;
    park_sender();
  endtask

  // zero periods and steps, then everything at its widest, upper data bits set, then unit periods with full steps
  task automatic test_register_extremes();
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(REG_NONE, 16'h5A5A);
    run_ticks(30, 50, 150);
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    run_ticks(30, 50, 150);
    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1000, 16'd1000, 16'd1000);
    run_ticks(20, 0, 3);
  endtask

  task automatic test_no_idle();
    load_regs(16'd300, 16'd200, 16'd1500, 16'd4000, 16'd1200, 16'd120, 16'd90, 16'd1000);
    send_idle = 0;
    rx_stall  = 0;
    noise_pct = 3;
    run_ticks(120, 50, 150);
  endtask

  task automatic test_sender_idle();
    load_regs(16'd500, 16'd500, 16'd2000, 16'd6000, 16'd2500, 16'd50, 16'd40, 16'd400);
    send_idle = 57;
    rx_stall  = 0;
    run_ticks(120, 50, 150);
  endtask

  task automatic test_receiver_stall();
    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
    send_idle = 0;
    rx_stall  = 57;
    run_ticks(60, 0, 2);
    load_regs(16'd250, 16'd400, 16'd1000, 16'd3000, 16'd800, 16'd200, 16'd150, 16'd700);
    run_ticks(60, 50, 150);
  endtask

  task automatic test_both_idle();
    load_regs(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
              16'($urandom_range(0, 4000)), 16'($urandom_range(0, 8000)),
              16'($urandom_range(0, 4000)), 16'($urandom()), 16'($urandom()),
              16'($urandom()));
    send_idle = 9;
    rx_stall  = 9;
    run_ticks(120, 50, 150);
  endtask

  // hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    load_regs(16'd300, 16'd300, 16'd1500, 16'd4000, 16'd1000, 16'd100, 16'd80, 16'd500);
    send_idle = 0;
    rx_stall  = 0;
    hold_req  = 48;
    run_ticks(25, 50, 150);
    wait_results();
    hold_req = 20;
    run_ticks(20, 50, 150);
  endtask

  task automatic test_time_wrap();
    load_regs(16'd300, 16'd200, 16'd2500, 16'd5000, 16'd2000, 16'd75, 16'd60, 16'd600);
    send_idle = 20;
    rx_stall  = 20;
    noise_pct = 0;
    clock_ms  = 32'hFFFF_F000;
    run_ticks(60, 50, 150);
  endtask

  initial begin
    int waited;
    rst                         = 1'b1;
    tick_bus.valid              = 1'b0;
    tick_bus.now_ms             = '0;
    tick_bus.light_mode         = MODE_OFF;
    tick_bus.turn_left_request  = 1'b0;
    tick_bus.turn_right_request = 1'b0;
    tick_bus.hazard_request     = 1'b0;
    tick_bus.brake_on           = 1'b0;
    tick_bus.reverse_selected   = 1'b0;
    tick_bus.interior_command   = CMD_KEEP;
    tick_bus.courtesy_command   = CMD_KEEP;
    tick_bus.sequence_trigger   = TRIG_NONE;
    cfg_bus.valid               = 1'b0;
    cfg_bus.index               = REG_TURN_ON;
    cfg_bus.data                = '0;
    lamp_bus.ready              = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ticks();
    test_register_extremes();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_time_wrap();

    park_sender();
    waited = 0;
    while (lamps_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (lamps_due.size() != 0) begin
      $error("%0d lamp words never arrived", lamps_due.size());
      fails++;
    end
    repeat (8) @(posedge clk);

    $display("checked %0d lamp words across %0d register writes", results_seen, writes_done);
    $display("covered idle and stall mixes, hold-off backpressure and timestamp wrap");
    if (fails == 0)
      $display("vehicle_light_sequencer test passed");
    else
      $display("vehicle_light_sequencer test failed");
    $finish;
  end

endmodule
